// ===== hdl/crg_pkg.sv =====
package crg_pkg;

  localparam int COORD_BITS    = 12;
  localparam int DIR_FRAC_BITS = 14;

  localparam int LIM_BITS   = 24;
  localparam int BASIS_BITS = 16;
  localparam int VEC_BITS   = 3 * BASIS_BITS;
  localparam int ORG_W      = 32;
  localparam int DIR_W      = 16;

  localparam int NMW  = COORD_BITS + 1;
  localparam int MW   = LIM_BITS + NMW;
  localparam int DVW  = MW + 2;
  localparam int DRW  = COORD_BITS + 1;
  localparam int PUW  = MW + 1;
  localparam int PW   = PUW + BASIS_BITS;
  localparam int OFW  = PW + 1;
  localparam int DW   = OFW + 1;
  localparam int NCH  = (DW + 7) / 8;
  localparam int PSW  = $clog2(NCH * 8);
  localparam int NRM  = 30;
  localparam int LW   = NRM + 1;
  localparam int SQW  = 2 * LW;
  localparam int SRW  = LW + 4;
  localparam int QB   = DIR_FRAC_BITS + 1;
  localparam int NUMW = NRM + DIR_FRAC_BITS + 1;

  typedef enum logic [2:0] {
    REG_MODE   = 3'd0,
    REG_RIGHT  = 3'd1,
    REG_TOP    = 3'd2,
    REG_DIST   = 3'd3,
    REG_SIZE   = 3'd4,
    REG_BASIS_U = 3'd5,
    REG_BASIS_V = 3'd6,
    REG_BASIS_W = 3'd7
  } crg_reg_t;

  typedef struct packed {
    logic                persp;
    logic [LIM_BITS-1:0] right;
    logic [LIM_BITS-1:0] top;
    logic [LIM_BITS-1:0] pdist;
    logic [LIM_BITS-1:0] isize;
    logic [VEC_BITS-1:0] bu;
    logic [VEC_BITS-1:0] bv;
    logic [VEC_BITS-1:0] bw;
  } crg_cfg_t;

  typedef struct packed {
    logic                       zero;
    logic [2:0]                 neg;
    logic [2:0][NRM-1:0]        mag;
    logic [2:0][ORG_W-1:0]      org;
  } crg_ray_t;

endpackage

// ===== hdl/crg_plane.sv =====
module crg_plane import crg_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [COORD_BITS-1:0]  px,
  input  logic [COORD_BITS-1:0]  py,
  input  crg_cfg_t               cfg,
  output logic                   out_valid,
  output logic signed [PUW-1:0]  pu,
  output logic signed [PUW-1:0]  pv
);

  logic [2*COORD_BITS+LIM_BITS-1:0] isz_ext;
  logic [COORD_BITS-1:0] wd_raw, ht_raw, wd, ht;
  logic signed [COORD_BITS+1:0] nu, nv;
  logic [COORD_BITS+1:0] au_full, av_full;
  logic [MW-1:0] mu_nxt, mv_nxt;
  logic [DRW-1:0] dvu, dvv;

  logic [MW-1:0] mu_r, mv_r;
  logic su0_r, sv0_r, v0_r;
  logic [DVW-1:0] qu_r [DVW+1];
  logic [DVW-1:0] qv_r [DVW+1];
  logic [DRW-1:0] ru_r [DVW+1];
  logic [DRW-1:0] rv_r [DVW+1];
  logic su_r [DVW+1];
  logic sv_r [DVW+1];
  logic vd_r [DVW+1];
  logic [DVW-1:0] qu_nxt [DVW];
  logic [DVW-1:0] qv_nxt [DVW];
  logic [DRW-1:0] ru_nxt [DVW];
  logic [DRW-1:0] rv_nxt [DVW];
  logic signed [PUW-1:0] pu_r, pv_r;
  logic vo_r;

  assign isz_ext = {{(2*COORD_BITS){1'b0}}, cfg.isize};
  assign wd_raw  = isz_ext[COORD_BITS-1:0];
  assign ht_raw  = isz_ext[2*COORD_BITS-1:COORD_BITS];
  assign wd      = (wd_raw == '0) ? COORD_BITS'(1) : wd_raw;
  assign ht      = (ht_raw == '0) ? COORD_BITS'(1) : ht_raw;
  assign dvu     = {wd, 1'b0};
  assign dvv     = {ht, 1'b0};

  assign nu      = $signed({1'b0, px, 1'b1}) - $signed({2'b00, wd});
  assign nv      = $signed({1'b0, py, 1'b1}) - $signed({2'b00, ht});
  assign au_full = nu[COORD_BITS+1] ? -nu : nu;
  assign av_full = nv[COORD_BITS+1] ? -nv : nv;
  assign mu_nxt  = cfg.right * au_full[NMW-1:0];
  assign mv_nxt  = cfg.top * av_full[NMW-1:0];

  always_comb begin
    logic [DRW:0] tu, tv;
    for (int k = 0; k < DVW; k++) begin
      tu = {ru_r[k], qu_r[k][DVW-1]};
      tv = {rv_r[k], qv_r[k][DVW-1]};
      if (tu >= {1'b0, dvu}) begin
        ru_nxt[k] = DRW'(tu - {1'b0, dvu});
        qu_nxt[k] = {qu_r[k][DVW-2:0], 1'b1};
      end else begin
        ru_nxt[k] = tu[DRW-1:0];
        qu_nxt[k] = {qu_r[k][DVW-2:0], 1'b0};
      end
      if (tv >= {1'b0, dvv}) begin
        rv_nxt[k] = DRW'(tv - {1'b0, dvv});
        qv_nxt[k] = {qv_r[k][DVW-2:0], 1'b1};
      end else begin
        rv_nxt[k] = tv[DRW-1:0];
        qv_nxt[k] = {qv_r[k][DVW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mu_r     <= mu_nxt;
      mv_r     <= mv_nxt;
      su0_r    <= nu[COORD_BITS+1];
      sv0_r    <= nv[COORD_BITS+1];
      qu_r[0]  <= {mu_r, 1'b0} + DVW'(wd);
      qv_r[0]  <= {mv_r, 1'b0} + DVW'(ht);
      ru_r[0]  <= '0;
      rv_r[0]  <= '0;
      su_r[0]  <= su0_r;
      sv_r[0]  <= sv0_r;
      for (int k = 0; k < DVW; k++) begin
        qu_r[k+1] <= qu_nxt[k];
        qv_r[k+1] <= qv_nxt[k];
        ru_r[k+1] <= ru_nxt[k];
        rv_r[k+1] <= rv_nxt[k];
        su_r[k+1] <= su_r[k];
        sv_r[k+1] <= sv_r[k];
      end
      pu_r <= su_r[DVW] ? -$signed({1'b0, qu_r[DVW][MW-1:0]})
                        :  $signed({1'b0, qu_r[DVW][MW-1:0]});
      pv_r <= sv_r[DVW] ? -$signed({1'b0, qv_r[DVW][MW-1:0]})
                        :  $signed({1'b0, qv_r[DVW][MW-1:0]});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      vo_r <= 1'b0;
      for (int k = 0; k <= DVW; k++) begin
        vd_r[k] <= 1'b0;
      end
    end else if (en) begin
      v0_r    <= in_valid;
      vd_r[0] <= v0_r;
      for (int k = 0; k < DVW; k++) begin
        vd_r[k+1] <= vd_r[k];
      end
      vo_r <= vd_r[DVW];
    end
  end

  assign out_valid = vo_r;
  assign pu        = pu_r;
  assign pv        = pv_r;

endmodule

// ===== hdl/crg_project.sv =====
module crg_project import crg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic signed [PUW-1:0] pu,
  input  logic signed [PUW-1:0] pv,
  input  crg_cfg_t              cfg,
  output logic                  out_valid,
  output crg_ray_t              ray
);

  function automatic logic signed [BASIS_BITS-1:0] comp_of(
    input logic [VEC_BITS-1:0] p, input int idx);
    return $signed(p[BASIS_BITS*idx +: BASIS_BITS]);
  endfunction

  function automatic logic [ORG_W-1:0] org_q16(input logic signed [OFW-1:0] v);
    logic [OFW-1:0] mo;
    logic [OFW:0]   m;
    logic [ORG_W-1:0] res;
    mo = v[OFW-1] ? -v : v;
    m  = ({1'b0, mo} + (OFW+1)'(1 << 13)) >> 14;
    if (v[OFW-1]) begin
      if (m > (OFW+1)'(64'h8000_0000)) begin
        res = 32'h8000_0000;
      end else begin
        res = -m[ORG_W-1:0];
      end
    end else begin
      if (m > (OFW+1)'(64'h7FFF_FFFF)) begin
        res = 32'h7FFF_FFFF;
      end else begin
        res = m[ORG_W-1:0];
      end
    end
    return res;
  endfunction

  logic signed [PW-1:0]  pa_r [3];
  logic signed [PW-1:0]  pb_r [3];
  logic signed [PW-1:0]  dw_r [3];
  logic signed [OFW-1:0] off_r [3];
  logic signed [DW-1:0]  dir_r [3];
  logic [DW-1:0]         mag2_r [3];
  logic [DW-1:0]         mag3_r [3];
  logic [DW-1:0]         mag4_r [3];
  logic [2:0]            neg2_r, neg3_r, neg4_r;
  logic [2:0][ORG_W-1:0] org2_r, org3_r, org4_r;
  logic [NCH-1:0]        nz_r;
  logic [2:0]            hi_r [NCH];
  logic [PSW-1:0]        pos_r;
  logic                  zero_r;
  crg_ray_t              ray_r;
  logic [5:0]            v_r;

  logic [NCH*8-1:0] bigp;
  logic [2:0]       hi_nxt [NCH];
  logic [PSW-1:0]   pos_nxt;
  logic [2:0][NRM-1:0] sh_nxt;

  assign bigp = (NCH*8)'(mag2_r[0] | mag2_r[1] | mag2_r[2]);

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      hi_nxt[c] = '0;
      for (int b = 0; b < 8; b++) begin
        if (bigp[8*c+b]) begin
          hi_nxt[c] = 3'(b);
        end
      end
    end
    pos_nxt = '0;
    for (int c = 0; c < NCH; c++) begin
      if (nz_r[c]) begin
        pos_nxt = PSW'(8*c) + PSW'(hi_r[c]);
      end
    end
  end

  always_comb begin
    logic [DW-1:0] s;
    for (int i = 0; i < 3; i++) begin
      if (pos_r >= PSW'(NRM-1)) begin
        s = mag4_r[i] >> (pos_r - PSW'(NRM-1));
      end else begin
        s = mag4_r[i] << (PSW'(NRM-1) - pos_r);
      end
      sh_nxt[i] = s[NRM-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pa_r[i]  <= pu * comp_of(cfg.bu, i);
        pb_r[i]  <= pv * comp_of(cfg.bv, i);
        dw_r[i]  <= $signed({1'b0, cfg.pdist}) * comp_of(cfg.bw, i);
        off_r[i] <= pa_r[i] + pb_r[i];
        if (cfg.persp) begin
          dir_r[i] <= pa_r[i] + pb_r[i] - dw_r[i];
        end else begin
          dir_r[i] <= -DW'(comp_of(cfg.bw, i));
        end
        neg2_r[i] <= dir_r[i][DW-1];
        mag2_r[i] <= dir_r[i][DW-1] ? -dir_r[i] : dir_r[i];
        org2_r[i] <= cfg.persp ? '0 : org_q16(off_r[i]);
        mag3_r[i] <= mag2_r[i];
        mag4_r[i] <= mag3_r[i];
      end
      for (int c = 0; c < NCH; c++) begin
        nz_r[c] <= |bigp[8*c +: 8];
        hi_r[c] <= hi_nxt[c];
      end
      neg3_r    <= neg2_r;
      org3_r    <= org2_r;
      neg4_r    <= neg3_r;
      org4_r    <= org3_r;
      pos_r     <= pos_nxt;
      zero_r    <= (nz_r == '0);
      ray_r.zero <= zero_r;
      ray_r.neg  <= neg4_r;
      ray_r.org  <= org4_r;
      ray_r.mag  <= sh_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[4:0], in_valid};
    end
  end

  assign out_valid = v_r[5];
  assign ray       = ray_r;

endmodule

// ===== hdl/crg_sqrt.sv =====
module crg_sqrt import crg_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  crg_ray_t        in_ray,
  output logic            out_valid,
  output logic [LW-1:0]   len,
  output crg_ray_t        ray
);

  logic [2*NRM-1:0] sq_r [3];
  crg_ray_t         ray0_r;
  logic             v0_r;
  logic [SQW-1:0]   n_r   [LW+1];
  logic [SRW-1:0]   rem_r [LW+1];
  logic [LW-1:0]    root_r [LW+1];
  crg_ray_t         ray_r [LW+1];
  logic             v_r   [LW+1];
  logic [SRW-1:0]   rem_nxt  [LW];
  logic [LW-1:0]    root_nxt [LW];

  always_comb begin
    logic [SRW-1:0] t, trial;
    for (int k = 0; k < LW; k++) begin
      t     = {rem_r[k][SRW-3:0], n_r[k][SQW-1:SQW-2]};
      trial = SRW'({root_r[k], 2'b01});
      if (t >= trial) begin
        rem_nxt[k]  = t - trial;
        root_nxt[k] = {root_r[k][LW-2:0], 1'b1};
      end else begin
        rem_nxt[k]  = t;
        root_nxt[k] = {root_r[k][LW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq_r[i] <= in_ray.mag[i] * in_ray.mag[i];
      end
      ray0_r    <= in_ray;
      n_r[0]    <= SQW'(sq_r[0]) + SQW'(sq_r[1]) + SQW'(sq_r[2]);
      rem_r[0]  <= '0;
      root_r[0] <= '0;
      ray_r[0]  <= ray0_r;
      for (int k = 0; k < LW; k++) begin
        n_r[k+1]    <= {n_r[k][SQW-3:0], 2'b00};
        rem_r[k+1]  <= rem_nxt[k];
        root_r[k+1] <= root_nxt[k];
        ray_r[k+1]  <= ray_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      for (int k = 0; k <= LW; k++) begin
        v_r[k] <= 1'b0;
      end
    end else if (en) begin
      v0_r   <= in_valid;
      v_r[0] <= v0_r;
      for (int k = 0; k < LW; k++) begin
        v_r[k+1] <= v_r[k];
      end
    end
  end

  assign out_valid = v_r[LW];
  assign len       = root_r[LW];
  assign ray       = ray_r[LW];

endmodule

// ===== hdl/crg_recip.sv =====
module crg_recip import crg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [LW-1:0]         len,
  input  crg_ray_t              in_ray,
  output logic                  out_valid,
  output logic [2:0][ORG_W-1:0] org,
  output logic [2:0][DIR_W-1:0] dir
);

  localparam logic [QB-1:0] LIM = QB'(1) << DIR_FRAC_BITS;

  logic [QB-1:0]  q_r   [QB+1][3];
  logic [LW-1:0]  r_r   [QB+1][3];
  logic [LW-1:0]  len_r [QB+1];
  crg_ray_t       ray_r [QB+1];
  logic           v_r   [QB+1];
  logic [QB-1:0]  q_nxt [QB][3];
  logic [LW-1:0]  r_nxt [QB][3];
  logic [NUMW-1:0] num [3];
  logic [2:0][ORG_W-1:0] org_r;
  logic [2:0][DIR_W-1:0] dir_r;
  logic [2:0][DIR_W-1:0] dir_nxt;
  logic out_valid_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num[i] = {in_ray.mag[i], {DIR_FRAC_BITS{1'b0}}} + NUMW'(len >> 1);
    end
  end

  always_comb begin
    logic [LW:0] t;
    for (int k = 0; k < QB; k++) begin
      for (int i = 0; i < 3; i++) begin
        t = {r_r[k][i], q_r[k][i][QB-1]};
        if (t >= {1'b0, len_r[k]}) begin
          r_nxt[k][i] = LW'(t - {1'b0, len_r[k]});
          q_nxt[k][i] = {q_r[k][i][QB-2:0], 1'b1};
        end else begin
          r_nxt[k][i] = t[LW-1:0];
          q_nxt[k][i] = {q_r[k][i][QB-2:0], 1'b0};
        end
      end
    end
  end

  always_comb begin
    logic [QB-1:0] qc;
    logic [QB:0]   sv;
    for (int i = 0; i < 3; i++) begin
      qc = (q_r[QB][i] > LIM) ? LIM : q_r[QB][i];
      sv = ray_r[QB].neg[i] ? -{1'b0, qc} : {1'b0, qc};
      dir_nxt[i] = ray_r[QB].zero ? '0 : DIR_W'($signed(sv));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        q_r[0][i] <= num[i][QB-1:0];
        r_r[0][i] <= LW'(num[i][NUMW-1:QB]);
      end
      len_r[0] <= len;
      ray_r[0] <= in_ray;
      for (int k = 0; k < QB; k++) begin
        for (int i = 0; i < 3; i++) begin
          q_r[k+1][i] <= q_nxt[k][i];
          r_r[k+1][i] <= r_nxt[k][i];
        end
        len_r[k+1] <= len_r[k];
        ray_r[k+1] <= ray_r[k];
      end
      org_r <= ray_r[QB].org;
      dir_r <= dir_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      for (int k = 0; k <= QB; k++) begin
        v_r[k] <= 1'b0;
      end
    end else if (en) begin
      v_r[0] <= in_valid;
      for (int k = 0; k < QB; k++) begin
        v_r[k+1] <= v_r[k];
      end
      out_valid_r <= v_r[QB];
    end
  end

  assign out_valid = out_valid_r;
  assign org       = org_r;
  assign dir       = dir_r;

  a_len_normalized: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[0] && !ray_r[0].zero |-> len_r[0] >= (LW'(1) << (NRM-1)))
    else $error("vector length below normalized range");

  a_quot_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[QB] && !ray_r[QB].zero |->
      q_r[QB][0] <= LIM && q_r[QB][1] <= LIM && q_r[QB][2] <= LIM)
    else $error("direction quotient exceeds unit");

  a_rem_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[QB] && !ray_r[QB].zero |->
      r_r[QB][0] < len_r[QB] && r_r[QB][1] < len_r[QB] && r_r[QB][2] < len_r[QB])
    else $error("divider remainder not below divisor");

endmodule

// ===== hdl/camera_ray_generator.sv =====
// Channel  Direction  Handshake                Payload
// in       slave      in_tvalid / in_tready    pixel_x, pixel_y
// out      master     out_tvalid / out_tready  origin_dx/dy/dz, dir_x/y/z
// cfg      slave      cfg_valid / cfg_ready    cfg_index, cfg_data
//
// One pixel is accepted per cycle while the pipeline advances; each ray passes
// through the bit-per-stage plane divider, square root and direction
// dividers. The whole pipeline advances whenever the output register
// is empty or being taken, so a stall holds every stage in place.
// Reset clears all valid bits and loads the default camera; cfg is always ready.
module camera_ray_generator import crg_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [23:0]   in_tdata,   // pixel_x, pixel_y
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [143:0]  out_tdata,  // origin_dx, origin_dy, origin_dz, dir_x, dir_y, dir_z
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [2:0]    cfg_index,
  input  logic [47:0]   cfg_data
);

  crg_cfg_t cfg_r;
  logic en;
  logic [COORD_BITS+11:0] px_ext, py_ext;
  logic pl_valid, pj_valid, sq_valid;
  logic signed [PUW-1:0] pu, pv;
  crg_ray_t pj_ray, sq_ray;
  logic [LW-1:0] len;
  logic [2:0][ORG_W-1:0] org;
  logic [2:0][DIR_W-1:0] dir;

  assign cfg_ready = 1'b1;
  assign en        = out_tready || !out_tvalid;
  assign in_tready = en;
  assign px_ext    = {{COORD_BITS{1'b0}}, in_tdata[11:0]};
  assign py_ext    = {{COORD_BITS{1'b0}}, in_tdata[23:12]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.persp <= 1'b1;
      cfg_r.right <= 24'd65536;
      cfg_r.top   <= 24'd65536;
      cfg_r.pdist <= 24'd65536;
      cfg_r.isize <= 24'd1966720;
      cfg_r.bu    <= 48'h0000_0000_4000;
      cfg_r.bv    <= 48'h0000_4000_0000;
      cfg_r.bw    <= 48'h4000_0000_0000;
    end else if (cfg_valid && cfg_ready) begin
      unique case (crg_reg_t'(cfg_index))
        REG_MODE:    cfg_r.persp <= cfg_data[0];
        REG_RIGHT:   cfg_r.right <= cfg_data[23:0];
        REG_TOP:     cfg_r.top   <= cfg_data[23:0];
        REG_DIST:    cfg_r.pdist <= cfg_data[23:0];
        REG_SIZE:    cfg_r.isize <= cfg_data[23:0];
        REG_BASIS_U: cfg_r.bu    <= cfg_data;
        REG_BASIS_V: cfg_r.bv    <= cfg_data;
        REG_BASIS_W: cfg_r.bw    <= cfg_data;
        default: ;
      endcase
    end
  end

  crg_plane u_plane (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tvalid),
    .px        (px_ext[COORD_BITS-1:0]),
    .py        (py_ext[COORD_BITS-1:0]),
    .cfg       (cfg_r),
    .out_valid (pl_valid),
    .pu        (pu),
    .pv        (pv)
  );

  crg_project u_project (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (pl_valid),
    .pu        (pu),
    .pv        (pv),
    .cfg       (cfg_r),
    .out_valid (pj_valid),
    .ray       (pj_ray)
  );

  crg_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (pj_valid),
    .in_ray    (pj_ray),
    .out_valid (sq_valid),
    .len       (len),
    .ray       (sq_ray)
  );

  crg_recip u_recip (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sq_valid),
    .len       (len),
    .in_ray    (sq_ray),
    .out_valid (out_tvalid),
    .org       (org),
    .dir       (dir)
  );

  assign out_tdata = {dir[2], dir[1], dir[0], org[2], org[1], org[0]};

endmodule
